@@ hw/rtl/segment_triangle_intersect_core_defines.svh @@
// Assertion macros for the segment/triangle intersection RTL.
`ifndef SEGMENT_TRIANGLE_INTERSECT_CORE_DEFINES_SVH
`define SEGMENT_TRIANGLE_INTERSECT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define STIC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define STIC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/stic_pkg.sv @@
// Shared types and codes for the segment/triangle intersection core.
package stic_pkg;

    typedef struct packed {
        logic valid;
        logic adv;
    } t_pipe_ctl;

    typedef enum logic [1:0] {
        CFG_OFS_X = 2'd0,
        CFG_OFS_Y = 2'd1,
        CFG_OFS_Z = 2'd2
    } t_cfg_idx;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TRI  = 1'b1;

endpackage

@@ hw/rtl/stic_geom.sv @@
// Cross and dot product pipeline: forms det, nu, nv and nt over four stages.
module stic_geom
    import stic_pkg::*;
#(
    parameter int C = 16,
    parameter int W = 3 * C + 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_pipe_ctl           i_ctl,
    input  logic signed [C:0]   i_e1 [3],
    input  logic signed [C:0]   i_e2 [3],
    input  logic signed [C+1:0] i_tv [3],
    input  logic signed [C:0]   i_dir [3],
    output logic                o_valid,
    output logic signed [W-1:0] o_det,
    output logic signed [W-1:0] o_nu,
    output logic signed [W-1:0] o_nv,
    output logic signed [W-1:0] o_nt
);

    localparam int PX = 2 * C + 3;
    localparam int PC = 2 * C + 4;
    localparam int D  = 3 * C + 6;

    logic                r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic signed [PX-1:0] r_pa [3];
    logic signed [PX-1:0] r_pb [3];
    logic signed [PX-1:0] r_qa [3];
    logic signed [PX-1:0] r_qb [3];
    logic signed [C:0]   r_a_e1 [3];
    logic signed [C:0]   r_a_e2 [3];
    logic signed [C+1:0] r_a_tv [3];
    logic signed [C:0]   r_a_dir [3];
    logic signed [PC-1:0] r_pv [3];
    logic signed [PC-1:0] r_qv [3];
    logic signed [C:0]   r_b_e1 [3];
    logic signed [C:0]   r_b_e2 [3];
    logic signed [C+1:0] r_b_tv [3];
    logic signed [C:0]   r_b_dir [3];
    logic signed [D-1:0] r_m_det [3];
    logic signed [D-1:0] r_m_nu [3];
    logic signed [D-1:0] r_m_nv [3];
    logic signed [D-1:0] r_m_nt [3];
    logic signed [W-1:0] r_det, r_nu, r_nv, r_nt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (i_ctl.adv) begin
            r_a_valid <= i_ctl.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        always_ff @(posedge i_clk) begin
            if (i_ctl.adv) begin
                r_pa[i]    <= PX'(i_dir[J]) * PX'(i_e2[K]);
                r_pb[i]    <= PX'(i_dir[K]) * PX'(i_e2[J]);
                r_qa[i]    <= PX'(i_tv[J]) * PX'(i_e1[K]);
                r_qb[i]    <= PX'(i_tv[K]) * PX'(i_e1[J]);
                r_a_e1[i]  <= i_e1[i];
                r_a_e2[i]  <= i_e2[i];
                r_a_tv[i]  <= i_tv[i];
                r_a_dir[i] <= i_dir[i];
                r_pv[i]    <= PC'(r_pa[i]) - PC'(r_pb[i]);
                r_qv[i]    <= PC'(r_qa[i]) - PC'(r_qb[i]);
                r_b_e1[i]  <= r_a_e1[i];
                r_b_e2[i]  <= r_a_e2[i];
                r_b_tv[i]  <= r_a_tv[i];
                r_b_dir[i] <= r_a_dir[i];
                r_m_det[i] <= D'(r_b_e1[i]) * D'(r_pv[i]);
                r_m_nu[i]  <= D'(r_b_tv[i]) * D'(r_pv[i]);
                r_m_nv[i]  <= D'(r_b_dir[i]) * D'(r_qv[i]);
                r_m_nt[i]  <= D'(r_b_e2[i]) * D'(r_qv[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_det <= W'(r_m_det[0]) + W'(r_m_det[1]) + W'(r_m_det[2]);
            r_nu  <= W'(r_m_nu[0]) + W'(r_m_nu[1]) + W'(r_m_nu[2]);
            r_nv  <= W'(r_m_nv[0]) + W'(r_m_nv[1]) + W'(r_m_nv[2]);
            r_nt  <= W'(r_m_nt[0]) + W'(r_m_nt[1]) + W'(r_m_nt[2]);
        end
    end

    assign o_valid = r_d_valid;
    assign o_det   = r_det;
    assign o_nu    = r_nu;
    assign o_nv    = r_nv;
    assign o_nt    = r_nt;

endmodule

@@ hw/rtl/stic_div.sv @@
// Pipelined restoring divider: three fractions over one shared divisor, one bit a stage.
module stic_div
    import stic_pkg::*;
#(
    parameter int W = 56,
    parameter int Q = 17
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_pipe_ctl    i_ctl,
    input  logic         i_hit,
    input  logic [W-1:0] i_den,
    input  logic [W-1:0] i_num [3],
    output logic         o_valid,
    output logic         o_hit,
    output logic [Q-1:0] o_quo [3]
);

    logic         r_valid [Q];
    logic         r_hit [Q];
    logic [W-1:0] r_den [Q];
    logic [W:0]   r_rem [Q][3];
    logic [Q-1:0] r_quo [Q][3];

    for (genvar s = 0; s < Q; s++) begin : g_stage
        logic         n_valid_in;
        logic         n_hit_in;
        logic [W-1:0] n_den_in;
        logic [W:0]   n_rem_in [3];
        logic [Q-1:0] n_quo_in [3];

        if (s == 0) begin : g_first
            assign n_valid_in = i_ctl.valid;
            assign n_hit_in   = i_hit;
            assign n_den_in   = i_den;
            for (genvar k = 0; k < 3; k++) begin : g_k
                assign n_rem_in[k] = (W+1)'(i_num[k]);
                assign n_quo_in[k] = '0;
            end
        end else begin : g_next
            assign n_valid_in = r_valid[s-1];
            assign n_hit_in   = r_hit[s-1];
            assign n_den_in   = r_den[s-1];
            for (genvar k = 0; k < 3; k++) begin : g_k
                assign n_rem_in[k] = {r_rem[s-1][k][W-1:0], 1'b0};
                assign n_quo_in[k] = r_quo[s-1][k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_ctl.adv) begin
                r_valid[s] <= n_valid_in;
            end
        end

        for (genvar k = 0; k < 3; k++) begin : g_lane
            logic n_bit;
            assign n_bit = n_rem_in[k] >= (W+1)'(n_den_in);
            always_ff @(posedge i_clk) begin
                if (i_ctl.adv) begin
                    r_rem[s][k] <= n_bit ? n_rem_in[k] - (W+1)'(n_den_in) : n_rem_in[k];
                    r_quo[s][k] <= {n_quo_in[k][Q-2:0], n_bit};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.adv) begin
                r_hit[s] <= n_hit_in;
                r_den[s] <= n_den_in;
            end
        end
    end

    assign o_valid = r_valid[Q-1];
    assign o_hit   = r_hit[Q-1];
    assign o_quo   = r_quo[Q-1];

endmodule

@@ hw/rtl/segment_triangle_intersect_core.sv @@
// Top level of the segment/triangle intersection core.
//
// Input channel (i_valid / o_stall): a transfer with i_mode low loads a segment from
// a (start) and b (end) and gives no result; with i_mode high it tests the triangle
// a, b, c against the loaded segment and gives exactly one result.
// Output channel (o_valid / i_stall): o_hit with param_t, bary_u and bary_v as
// unsigned fixed point with FRAC_BITS fraction bits; all read zero on a miss.
// Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0..2 writes the
// origin offset x, y or z; other indexes are dropped. Write only while idle.
// Throughput: one item per cycle while the receiver does not stall with a result
// held. A triangle's result passes through the input stage, the four-stage product
// pipeline, two classify stages, one divider stage per quotient bit and the output
// register.
// When the receiver stalls with a result held, the whole pipeline holds and o_stall
// rises; nothing is lost or repeated. Synchronous reset clears the segment, the
// offsets and all valid bits; the block takes items as soon as reset is released.
module segment_triangle_intersect_core
    import stic_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_mode,
    input  logic signed [COORD_BITS-1:0] i_a_x,
    input  logic signed [COORD_BITS-1:0] i_a_y,
    input  logic signed [COORD_BITS-1:0] i_a_z,
    input  logic signed [COORD_BITS-1:0] i_b_x,
    input  logic signed [COORD_BITS-1:0] i_b_y,
    input  logic signed [COORD_BITS-1:0] i_b_z,
    input  logic signed [COORD_BITS-1:0] i_c_x,
    input  logic signed [COORD_BITS-1:0] i_c_y,
    input  logic signed [COORD_BITS-1:0] i_c_z,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit,
    output logic [FRAC_BITS:0]           o_param_t,
    output logic [FRAC_BITS:0]           o_bary_u,
    output logic [FRAC_BITS:0]           o_bary_v,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [COORD_BITS-1:0]        i_cfg_data
);

`include "segment_triangle_intersect_core_defines.svh"

    localparam int C = COORD_BITS;
    localparam int W = 3 * C + 8;
    localparam int Q = FRAC_BITS + 1;

    logic                adv;
    logic                acc;
    logic signed [C-1:0] in_a [3];
    logic signed [C-1:0] in_b [3];
    logic signed [C-1:0] in_c [3];

    logic signed [C-1:0] r_start [3];
    logic signed [C:0]   r_dir [3];
    logic signed [C-1:0] r_ofs [3];

    logic                r_s1_valid;
    logic signed [C:0]   r_e1 [3];
    logic signed [C:0]   r_e2 [3];
    logic signed [C+1:0] r_tv [3];
    logic signed [C:0]   r_s1_dir [3];

    t_pipe_ctl           geom_ctl;
    logic                geom_valid;
    logic signed [W-1:0] geom_det, geom_nu, geom_nv, geom_nt;

    logic                r_n_valid;
    logic signed [W-1:0] r_n_det, r_n_nu, r_n_nv, r_n_nt;

    logic                n_miss;
    logic                r_k_valid;
    logic                r_k_hit;
    logic [W-1:0]        r_k_den;
    logic [W-1:0]        r_k_num [3];

    t_pipe_ctl           div_ctl;
    logic                div_valid;
    logic                div_hit;
    logic [Q-1:0]        div_quo [3];

    logic                r_out_valid;
    logic                r_out_hit;
    logic [Q-1:0]        r_out_t, r_out_u, r_out_v;

    assign adv         = !r_out_valid || !i_stall;
    assign acc         = i_valid && adv;
    assign o_stall     = !adv;
    assign o_cfg_ready = 1'b1;

    assign in_a = '{i_a_x, i_a_y, i_a_z};
    assign in_b = '{i_b_x, i_b_y, i_b_z};
    assign in_c = '{i_c_x, i_c_y, i_c_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '{default: '0};
            r_dir   <= '{default: '0};
            r_ofs   <= '{default: '0};
        end else begin
            if (acc && i_mode == MODE_LOAD) begin
                for (int i = 0; i < 3; i++) begin
                    r_start[i] <= in_a[i];
                    r_dir[i]   <= (C+1)'(in_b[i]) - (C+1)'(in_a[i]);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_OFS_X: r_ofs[0] <= i_cfg_data;
                    CFG_OFS_Y: r_ofs[1] <= i_cfg_data;
                    CFG_OFS_Z: r_ofs[2] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_n_valid  <= 1'b0;
            r_k_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= acc && i_mode == MODE_TRI;
            r_n_valid   <= geom_valid;
            r_k_valid   <= r_n_valid;
            r_out_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i]     <= (C+1)'(in_b[i]) - (C+1)'(in_a[i]);
                r_e2[i]     <= (C+1)'(in_c[i]) - (C+1)'(in_a[i]);
                r_tv[i]     <= (C+2)'(r_start[i]) + (C+2)'(r_ofs[i]) - (C+2)'(in_a[i]);
                r_s1_dir[i] <= r_dir[i];
            end
        end
    end

    assign geom_ctl = '{valid: r_s1_valid, adv: adv};

    stic_geom #(
        .C (C),
        .W (W)
    ) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (geom_ctl),
        .i_e1    (r_e1),
        .i_e2    (r_e2),
        .i_tv    (r_tv),
        .i_dir   (r_s1_dir),
        .o_valid (geom_valid),
        .o_det   (geom_det),
        .o_nu    (geom_nu),
        .o_nv    (geom_nv),
        .o_nt    (geom_nt)
    );

    // Make det non-negative, negating nu, nv and nt with it.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_n_det <= geom_det[W-1] ? -geom_det : geom_det;
            r_n_nu  <= geom_det[W-1] ? -geom_nu  : geom_nu;
            r_n_nv  <= geom_det[W-1] ? -geom_nv  : geom_nv;
            r_n_nt  <= geom_det[W-1] ? -geom_nt  : geom_nt;
        end
    end

    always_comb begin
        n_miss = (r_n_det == '0) || r_n_nu[W-1] || (r_n_det < r_n_nu) || r_n_nv[W-1]
              || ((W+1)'(r_n_det) < (W+1)'(r_n_nu) + (W+1)'(r_n_nv))
              || r_n_nt[W-1] || (r_n_det < r_n_nt);
    end

    // A miss divides zero by one, so its quotients come out zero.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_k_hit    <= !n_miss;
            r_k_den    <= n_miss ? W'(1) : W'(r_n_det);
            r_k_num[0] <= n_miss ? '0 : W'(r_n_nt);
            r_k_num[1] <= n_miss ? '0 : W'(r_n_nu);
            r_k_num[2] <= n_miss ? '0 : W'(r_n_nv);
        end
    end

    assign div_ctl = '{valid: r_k_valid, adv: adv};

    stic_div #(
        .W (W),
        .Q (Q)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_hit   (r_k_hit),
        .i_den   (r_k_den),
        .i_num   (r_k_num),
        .o_valid (div_valid),
        .o_hit   (div_hit),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_hit <= div_hit;
            r_out_t   <= div_quo[0];
            r_out_u   <= div_quo[1];
            r_out_v   <= div_quo[2];
        end
    end

    assign o_valid   = r_out_valid;
    assign o_hit     = r_out_hit;
    assign o_param_t = r_out_t;
    assign o_bary_u  = r_out_u;
    assign o_bary_v  = r_out_v;

    `STIC_ASSERT_IMP(a_miss_zero, o_valid && !o_hit, o_param_t == '0 && o_bary_u == '0 && o_bary_v == '0, "miss result not zero")
    `STIC_ASSERT_IMP(a_bary_sum, o_valid && o_hit, (Q+1)'(o_bary_u) + (Q+1)'(o_bary_v) <= ((Q+1)'(1) << FRAC_BITS), "u plus v above one")
    `STIC_ASSERT_IMP(a_stall_cause, o_stall, o_valid && i_stall, "input stalled without held result")
    `STIC_ASSERT_NXT(a_cfg_x, i_cfg_valid && o_cfg_ready && i_cfg_index == CFG_OFS_X, r_ofs[0] == $past(i_cfg_data), "offset x not written")

endmodule

@@ bench/segment_triangle_intersect_core_checker.sv @@
// Checker for the segment/triangle intersection core: tracks segment and offsets, predicts hits.
module segment_triangle_intersect_core_checker
    import stic_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         mode,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic signed [COORD_BITS-1:0] a_z,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic signed [COORD_BITS-1:0] b_z,
    input  logic signed [COORD_BITS-1:0] c_x,
    input  logic signed [COORD_BITS-1:0] c_y,
    input  logic signed [COORD_BITS-1:0] c_z,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic                         hit,
    input  logic [FRAC_BITS:0]           param_t,
    input  logic [FRAC_BITS:0]           bary_u,
    input  logic [FRAC_BITS:0]           bary_v,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [COORD_BITS-1:0]        cfg_data,
    output int                           mismatches,
    output int                           outstanding
);

    typedef logic signed [127:0] wide_t;
    typedef wide_t vec_t [3];

    typedef struct packed {
        logic               hit;
        logic [FRAC_BITS:0] t;
        logic [FRAC_BITS:0] u;
        logic [FRAC_BITS:0] v;
    } crossing_t;

    vec_t      seg_start;
    vec_t      seg_dir;
    vec_t      origin_ofs;
    crossing_t pending_crossings[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic wide_t widen(input logic signed [COORD_BITS-1:0] v);
        return v;
    endfunction

    function automatic wide_t dot3(input vec_t p, input vec_t q);
        return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
    endfunction

    function automatic void cross3(input vec_t p, input vec_t q, output vec_t r);
        r[0] = p[1] * q[2] - p[2] * q[1];
        r[1] = p[2] * q[0] - p[0] * q[2];
        r[2] = p[0] * q[1] - p[1] * q[0];
    endfunction

    function automatic logic [FRAC_BITS:0] to_fixed(input wide_t num, input wide_t den);
        wide_t q;
        q = (num <<< FRAC_BITS) / den;
        return q[FRAC_BITS:0];
    endfunction

    function automatic crossing_t predict_crossing(input vec_t va, input vec_t vb,
                                                   input vec_t vc);
        vec_t      e1, e2, tv, pv, qv;
        wide_t     det, nu, nv, nt;
        crossing_t r;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            e1[i] = vb[i] - va[i];
            e2[i] = vc[i] - va[i];
            tv[i] = seg_start[i] + origin_ofs[i] - va[i];
        end
        cross3(seg_dir, e2, pv);
        det = dot3(e1, pv);
        if (det == 0) return r;
        nu = dot3(tv, pv);
        cross3(tv, e1, qv);
        nv = dot3(seg_dir, qv);
        nt = dot3(e2, qv);
        if (det < 0) begin
            det = -det;
            nu  = -nu;
            nv  = -nv;
            nt  = -nt;
        end
        if (nu < 0 || nu > det) return r;
        if (nv < 0 || nu + nv > det) return r;
        if (nt < 0 || nt > det) return r;
        r.hit = 1'b1;
        r.t   = to_fixed(nt, det);
        r.u   = to_fixed(nu, det);
        r.v   = to_fixed(nv, det);
        return r;
    endfunction

    always @(posedge clk) begin
        vec_t      va, vb, vc;
        crossing_t want;
        if (!rst_n) begin
            for (int i = 0; i < 3; i++) begin
                seg_start[i]  = 0;
                seg_dir[i]    = 0;
                origin_ofs[i] = 0;
            end
            pending_crossings.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (t_cfg_idx'(cfg_index))
                    CFG_OFS_X: origin_ofs[0] = widen(cfg_data);
                    CFG_OFS_Y: origin_ofs[1] = widen(cfg_data);
                    CFG_OFS_Z: origin_ofs[2] = widen(cfg_data);
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                va = '{widen(a_x), widen(a_y), widen(a_z)};
                vb = '{widen(b_x), widen(b_y), widen(b_z)};
                vc = '{widen(c_x), widen(c_y), widen(c_z)};
                if (mode == MODE_LOAD) begin
                    for (int i = 0; i < 3; i++) begin
                        seg_start[i] = va[i];
                        seg_dir[i]   = vb[i] - va[i];
                    end
                end else begin
                    pending_crossings.push_back(predict_crossing(va, vb, vc));
                end
            end
            if (out_valid && !out_stall) begin
                if (pending_crossings.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: hit=%0d t=%0d u=%0d v=%0d",
                                 hit, param_t, bary_u, bary_v);
                    mismatches++;
                end else begin
                    want = pending_crossings.pop_front();
                    if (want.hit !== hit || want.t !== param_t || want.u !== bary_u ||
                        want.v !== bary_v) begin
                        if (mismatches < 10)
                            $display("mismatch: expected hit=%0d t=%0d u=%0d v=%0d, got hit=%0d t=%0d u=%0d v=%0d",
                                     want.hit, want.t, want.u, want.v,
                                     hit, param_t, bary_u, bary_v);
                        mismatches++;
                    end
                end
            end
        end
        outstanding = pending_crossings.size();
    end

endmodule

@@ bench/segment_triangle_intersect_core_tb.sv @@
// Testbench top for the segment/triangle intersection core: stimulus, handshakes, verdict.
module segment_triangle_intersect_core_tb;
    import stic_pkg::*;

    localparam int         COORD_BITS     = 16;
    localparam int         FRAC_BITS      = 16;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         IDLE_LIMIT     = 5000;
    localparam int         PHASE_ITEMS    = 600;
    localparam logic [1:0] CFG_IDX_SPARE  = 2'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_mode = MODE_LOAD;
    coord_t               i_a_x = '0, i_a_y = '0, i_a_z = '0;
    coord_t               i_b_x = '0, i_b_y = '0, i_b_z = '0;
    coord_t               i_c_x = '0, i_c_y = '0, i_c_z = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_hit;
    logic [FRAC_BITS:0]   o_param_t, o_bary_u, o_bary_v;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [1:0]           i_cfg_index = CFG_OFS_X;
    logic [COORD_BITS-1:0] i_cfg_data = '0;

    int mismatches, outstanding;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int seg_s [3];
    int seg_e [3];

    segment_triangle_intersect_core #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (.*);

    segment_triangle_intersect_core_checker #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) checker_inst (
        .clk(i_clk), .rst_n(i_rst_n), .in_valid(i_valid), .in_stall(o_stall),
        .mode(i_mode), .a_x(i_a_x), .a_y(i_a_y), .a_z(i_a_z),
        .b_x(i_b_x), .b_y(i_b_y), .b_z(i_b_z), .c_x(i_c_x), .c_y(i_c_y), .c_z(i_c_z),
        .out_valid(o_valid), .out_stall(i_stall), .hit(o_hit), .param_t(o_param_t),
        .bary_u(o_bary_u), .bary_v(o_bary_v), .cfg_valid(i_cfg_valid),
        .cfg_ready(o_cfg_ready), .cfg_index(i_cfg_index), .cfg_data(i_cfg_data),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic coord_t clip(input int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return coord_t'(v);
    endfunction

    function automatic int spread(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic coord_t any_coord();
        return coord_t'($urandom);
    endfunction

    task automatic send_item(input logic mode, input coord_t ax, ay, az, bx, by, bz,
                             cx, cy, cz);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_mode = mode;
        {i_a_x, i_a_y, i_a_z} = {ax, ay, az};
        {i_b_x, i_b_y, i_b_z} = {bx, by, bz};
        {i_c_x, i_c_y, i_c_z} = {cx, cy, cz};
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        if (mode == MODE_LOAD) begin
            seg_s = '{ax, ay, az};
            seg_e = '{bx, by, bz};
        end
    endtask

    task automatic settle();
        i_valid = 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        i_cfg_index = idx;
        i_cfg_data  = value[COORD_BITS-1:0];
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_offsets(input int ox, oy, oz);
        write_reg(CFG_OFS_X, ox);
        write_reg(CFG_OFS_Y, oy);
        write_reg(CFG_OFS_Z, oz);
    endtask

    task automatic send_random_item();
        int     pick, k, r;
        int     m [3];
        int     d0 [3];
        int     d1 [3];
        coord_t s [3];
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            for (int i = 0; i < 3; i++) s[i] = clip(spread(12000));
            send_item(MODE_LOAD, s[0], s[1], s[2], clip(s[0] + spread(12000)),
                      clip(s[1] + spread(12000)), clip(s[2] + spread(12000)),
                      any_coord(), any_coord(), any_coord());
        end else if (pick < 9) begin
            send_item(MODE_LOAD, any_coord(), any_coord(), any_coord(), any_coord(),
                      any_coord(), any_coord(), any_coord(), any_coord(), any_coord());
        end else if (pick < 82) begin
            k = $urandom_range(0, 16);
            r = $urandom_range(1, 3000);
            for (int i = 0; i < 3; i++) begin
                m[i]  = seg_s[i] + (seg_e[i] - seg_s[i]) * k / 16;
                d0[i] = spread(r);
                d1[i] = spread(r);
            end
            send_item(MODE_TRI, clip(m[0] + d0[0]), clip(m[1] + d0[1]), clip(m[2] + d0[2]),
                      clip(m[0] + d1[0]), clip(m[1] + d1[1]), clip(m[2] + d1[2]),
                      clip(m[0] - d0[0] - d1[0] + spread(r / 4)),
                      clip(m[1] - d0[1] - d1[1] + spread(r / 4)),
                      clip(m[2] - d0[2] - d1[2] + spread(r / 4)));
        end else if (pick < 90) begin
            send_item(MODE_TRI, any_coord(), any_coord(), any_coord(), any_coord(),
                      any_coord(), any_coord(), any_coord(), any_coord(), any_coord());
        end else begin
            for (int i = 0; i < 3; i++) begin
                d0[i] = spread(4000);
                d1[i] = spread(4000);
            end
            send_item(MODE_TRI, clip(d0[0]), clip(d0[1]), clip(d0[2]),
                      clip(d1[0]), clip(d1[1]), clip(d1[2]),
                      clip(2 * d1[0] - d0[0]), clip(2 * d1[1] - d0[1]),
                      clip(2 * d1[2] - d0[2]));
        end
    endtask

    task automatic run_phase(input int sender_pct, input int receiver_pct,
                             input bit with_hold);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (with_hold && n == PHASE_ITEMS / 3) hold_token++;
            if (n == PHASE_ITEMS / 2) settle();
            send_random_item();
        end
        settle();
    endtask

    initial begin
        seg_s = '{0, 0, 0};
        seg_e = '{0, 0, 0};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 67;
        send_item(MODE_TRI, 1, 2, 3, 40, -5, 7, -9, 30, 11);
        send_item(MODE_LOAD, 0, 0, -10, 0, 0, 10, 0, 0, 0);
        send_item(MODE_TRI, -5, -5, 10, 20, -5, 10, -5, 20, 10);
        send_item(MODE_TRI, -5, 20, 10, 20, -5, 10, -5, -5, 10);
        send_item(MODE_TRI, -5, -5, -10, 20, -5, -10, -5, 20, -10);
        send_item(MODE_TRI, 0, 0, 0, 10, 0, 0, 0, 10, 0);
        send_item(MODE_TRI, 10, 0, 0, 0, 0, 0, 10, 10, 0);
        send_item(MODE_TRI, -10, 10, 0, 10, -10, 0, 10, 10, 0);
        send_item(MODE_TRI, 0, 0, 0, 10, 0, 0, 0, 0, 10);
        send_item(MODE_TRI, -5, -5, 20, 20, -5, 20, -5, 20, 20);
        send_item(MODE_TRI, -32768, -32768, -32768, 32767, 32767, 32767,
                  -32768, 32767, 0);
        send_item(MODE_LOAD, -32768, -32768, -32768, 32767, 32767, 32767,
                  32767, -32768, 32767);
        send_item(MODE_TRI, 32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767);
        send_item(MODE_TRI, 32767, 32767, -32768, -32768, -32768, 32767,
                  32767, -32768, -32768);
        send_item(MODE_LOAD, 100, 200, -300, -100, -200, 300, -1, -1, -1);
        send_item(MODE_TRI, -50, 0, 0, 50, -60, 0, 50, 60, 0);
        settle();
        write_offsets(7, -3, 20);
        write_reg(CFG_IDX_SPARE, 12345);
        send_item(MODE_TRI, -50, 0, 0, 50, -60, 0, 50, 60, 0);
        send_item(MODE_TRI, -50, 0, 40, 50, -60, 40, 50, 60, 40);
        settle();
        write_offsets(32767, -32768, 32767);
        send_item(MODE_TRI, -50, 0, 0, 50, -60, 0, 50, 60, 0);
        send_item(MODE_TRI, 32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767);
        settle();
        write_offsets(-32768, 32767, -32768);
        send_item(MODE_TRI, 32767, 32767, -32768, -32768, -32768, 32767,
                  32767, -32768, -32768);
        settle();

        write_offsets(0, 0, 0);
        run_phase(21, 67, 1'b0);
        write_offsets(spread(60), spread(60), spread(60));
        run_phase(67, 21, 1'b0);
        write_offsets(-2, 5, 1);
        run_phase(0, 0, 1'b1);

        if (mismatches == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ segment_triangle_intersect_core.f @@
+incdir+hw/rtl
hw/rtl/stic_pkg.sv
hw/rtl/stic_geom.sv
hw/rtl/stic_div.sv
hw/rtl/segment_triangle_intersect_core.sv
bench/segment_triangle_intersect_core_checker.sv
bench/segment_triangle_intersect_core_tb.sv
